// ===== rtl/core/ttip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared widths, character codes and types of the text-to-integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

   localparam int CharWidth  = 8;
   localparam int ValueWidth = 64;
   localparam int DigitWidth = 5;
   localparam int WideWidth  = ValueWidth + 4;

   localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
   localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CharWidth-1:0] CH_LX    = 8'h78;
   localparam logic [CharWidth-1:0] CH_UX    = 8'h58;
   localparam logic [CharWidth-1:0] CH_LB    = 8'h62;
   localparam logic [CharWidth-1:0] CH_UB    = 8'h42;
   localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CH_ONE   = 8'h31;
   localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
   localparam logic [CharWidth-1:0] CH_LA    = 8'h61;
   localparam logic [CharWidth-1:0] CH_LF    = 8'h66;
   localparam logic [CharWidth-1:0] CH_UA    = 8'h41;
   localparam logic [CharWidth-1:0] CH_UF    = 8'h46;

   localparam logic [DigitWidth-1:0] NOT_A_DIGIT = 5'd16;

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_SIGNED = 4'b0010,
      PH_ZERO   = 4'b0100,
      PH_DIGITS = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_BIN = 2'd2
   } radix_type;

   function automatic logic [DigitWidth-1:0] digit_value(input logic [CharWidth-1:0] c,
                                                         input radix_type rx);
      logic [DigitWidth-1:0] d;
      d = NOT_A_DIGIT;
      if (rx == RX_BIN) begin
         if (c == CH_ZERO || c == CH_ONE) begin
            d = DigitWidth'(c - CH_ZERO);
         end
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         d = DigitWidth'(c - CH_ZERO);
      end else if (rx == RX_HEX) begin
         if (c >= CH_LA && c <= CH_LF) begin
            d = DigitWidth'(c - CH_LA) + DigitWidth'(10);
         end else if (c >= CH_UA && c <= CH_UF) begin
            d = DigitWidth'(c - CH_UA) + DigitWidth'(10);
         end
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/ttip_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_req_if / ttip_rsp_if
// Valid/ready channels carrying characters in and parsed values out.
// ----------------------------------------------------------------------------
interface ttip_req_if import ttip_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 final_char;
   logic                 empty_text;

   modport source (output valid, output char_code, output final_char,
                   output empty_text, input ready);
   modport sink   (input valid, input char_code, input final_char,
                   input empty_text, output ready);
endinterface

interface ttip_rsp_if import ttip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] number_bits;
   logic                  parse_ok;

   modport source (output valid, output number_bits, output parse_ok, input ready);
   modport sink   (input valid, input number_bits, input parse_ok, output ready);
endinterface

// ===== rtl/core/text_to_integer_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_unit
// Streaming parser of signed decimal, 0x hex and 0b binary numerals.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ASCII character per transaction, with final_char on the
//   last character of a numeral, or empty_text for a zero-length numeral.
//   rsp carries one transaction per numeral: number_bits (two's complement,
//   zero on failure) and parse_ok.
//   One character is accepted per cycle, sustained while no result is stalled.
//   The result appears in the cycle after the final character is accepted.
//   The result register is the only buffer: while it holds a result that the
//   receiver stalls, req.ready stays low; it rises again the cycle the result
//   is taken (ready = !rsp.valid || rsp.ready).
//   The per-character work is a shift-add by 2, 10 or 16 with overflow check
//   on the 64-bit accumulator.
//   Reset returns the parser to the start of a numeral and empties rsp.
// ----------------------------------------------------------------------------
module text_to_integer_parser_unit import ttip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ttip_req_if.sink   req,
   ttip_rsp_if.source rsp
);

   phase_type             phase_ff, phase_in;
   radix_type             radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic                  ok_ff, ok_in;
   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff;
   logic [ValueWidth-1:0] number_ff, number_in;
   logic                  parse_ok_ff, parse_ok_in;

   logic                  accept;
   logic                  do_digit;
   logic                  out_load;
   logic [DigitWidth-1:0] digit;
   logic [WideWidth-1:0]  acc_wide;
   logic [WideWidth-1:0]  product;
   logic [WideWidth-1:0]  sum;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign digit    = digit_value(req.char_code, radix_ff);
   assign acc_wide = WideWidth'(acc_ff);

   always_comb begin
      case (radix_ff)
         RX_HEX:  product = acc_wide << 4;
         RX_BIN:  product = acc_wide << 1;
         default: product = (acc_wide << 3) + (acc_wide << 1);
      endcase
   end

   assign sum = product + WideWidth'(digit);

   always_comb begin
      phase_in    = phase_ff;
      radix_in    = radix_ff;
      neg_in      = neg_ff;
      ok_in       = ok_ff;
      acc_in      = acc_ff;
      do_digit    = 1'b0;
      out_load    = 1'b0;
      number_in   = '0;
      parse_ok_in = 1'b0;
      if (accept) begin
         if (req.empty_text) begin
            out_load = 1'b1;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (req.char_code == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGNED;
                  end else if (req.char_code == CH_PLUS) begin
                     phase_in = PH_SIGNED;
                  end else if (req.char_code == CH_ZERO) begin
                     phase_in = PH_ZERO;
                  end else begin
                     do_digit = 1'b1;
                  end
               end
               PH_SIGNED: begin
                  if (req.char_code == CH_ZERO) begin
                     phase_in = PH_ZERO;
                  end else begin
                     do_digit = 1'b1;
                  end
               end
               PH_ZERO: begin
                  if (req.char_code == CH_LX || req.char_code == CH_UX) begin
                     radix_in = RX_HEX;
                     phase_in = PH_DIGITS;
                  end else if (req.char_code == CH_LB || req.char_code == CH_UB) begin
                     radix_in = RX_BIN;
                     phase_in = PH_DIGITS;
                  end else begin
                     do_digit = 1'b1;
                  end
               end
               default: do_digit = 1'b1;
            endcase
            if (do_digit) begin
               phase_in = PH_DIGITS;
               if (ok_ff) begin
                  if (digit == NOT_A_DIGIT || |sum[WideWidth-1:ValueWidth]) begin
                     ok_in = 1'b0;
                  end else begin
                     acc_in = sum[ValueWidth-1:0];
                  end
               end
            end
            if (req.final_char) begin
               out_load    = 1'b1;
               parse_ok_in = ok_in;
               if (ok_in) begin
                  number_in = neg_in ? (~acc_in + ValueWidth'(1)) : acc_in;
               end
            end
         end
         if (out_load) begin
            phase_in = PH_START;
            radix_in = RX_DEC;
            neg_in   = 1'b0;
            ok_in    = 1'b1;
            acc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         radix_ff     <= RX_DEC;
         neg_ff       <= 1'b0;
         ok_ff        <= 1'b1;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         ok_ff    <= ok_in;
         acc_ff   <= acc_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         number_ff   <= number_in;
         parse_ok_ff <= parse_ok_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.number_bits = number_ff;
   assign rsp.parse_ok    = parse_ok_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while result stalled");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !parse_ok_ff |-> number_ff == '0)
      else $error("failed parse with nonzero value");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req.final_char || req.empty_text)
      |=> rsp_valid_ff && phase_ff == PH_START && acc_ff == '0 && ok_ff)
      else $error("numeral end did not deliver and clear");

   a_radix_code: assert property (@(posedge clock) disable iff (reset)
      radix_ff != RX_DEC |-> phase_ff == PH_DIGITS)
      else $error("prefix radix outside digit phase");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_to_integer_parser_unit. Directed numerals, then
// random signed decimal / hex / binary numerals, boundary values, noise bytes
// and aborted numerals are streamed one character per transaction. A local
// parser predicts each result, which is compared field by field in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import ttip_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned TotalChars = 1550;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 final_char;
      logic                 empty_text;
   } char_item_type;

   typedef struct packed {
      logic [ValueWidth-1:0] number_bits;
      logic                  parse_ok;
   } parsed_number_type;

   logic clock;
   logic reset;

   ttip_req_if req_ch ();
   ttip_rsp_if rsp_ch ();

   text_to_integer_parser_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   char_item_type     pending_chars[$];
   parsed_number_type parsed_numbers[$];
   logic [7:0]        numeral[$];

   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   logic           req_taken = 1'b0;
   int unsigned    send_gap = 0;
   int unsigned    stall_left = 0;
   bit             send_burst = 1'b0;
   bit             take_burst = 1'b0;

   // local parser state
   phase_type             num_phase;
   bit                    num_negative;
   radix_type             num_radix;
   logic [ValueWidth-1:0] num_value;
   bit                    num_valid;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_numeral();
      num_phase    = PH_START;
      num_negative = 1'b0;
      num_radix    = RX_DEC;
      num_value    = '0;
      num_valid    = 1'b1;
   endfunction

   function automatic logic [DigitWidth-1:0] digit_weight(logic [7:0] c, radix_type rx);
      case (rx)
         RX_BIN: begin
            if (c == CH_ZERO) return DigitWidth'(0);
            if (c == CH_ONE) return DigitWidth'(1);
         end
         RX_HEX: begin
            if (c >= CH_ZERO && c <= CH_NINE) return DigitWidth'(c - CH_ZERO);
            if (c >= CH_LA && c <= CH_LF) return DigitWidth'(c - CH_LA + 8'd10);
            if (c >= CH_UA && c <= CH_UF) return DigitWidth'(c - CH_UA + 8'd10);
         end
         default: begin
            if (c >= CH_ZERO && c <= CH_NINE) return DigitWidth'(c - CH_ZERO);
         end
      endcase
      return NOT_A_DIGIT;
   endfunction

   function automatic void accept_digit(logic [7:0] c);
      logic [DigitWidth-1:0] d;
      logic [WideWidth-1:0]  wide;
      logic [WideWidth-1:0]  base;
      num_phase = PH_DIGITS;
      if (!num_valid) return;
      d = digit_weight(c, num_radix);
      if (d == NOT_A_DIGIT) begin
         num_valid = 1'b0;
         return;
      end
      base = (num_radix == RX_HEX) ? WideWidth'(16) :
             (num_radix == RX_BIN) ? WideWidth'(2) : WideWidth'(10);
      wide = WideWidth'(num_value) * base + WideWidth'(d);
      if (wide[WideWidth-1:ValueWidth] != '0) num_valid = 1'b0;
      else num_value = wide[ValueWidth-1:0];
   endfunction

   function automatic void parse_char(char_item_type it);
      parsed_number_type res;
      if (it.empty_text) begin
         clear_numeral();
         res.number_bits = '0;
         res.parse_ok    = 1'b0;
         parsed_numbers.push_back(res);
         return;
      end
      case (num_phase)
         PH_START: begin
            if (it.char_code == CH_MINUS) begin
               num_negative = 1'b1;
               num_phase    = PH_SIGNED;
            end else if (it.char_code == CH_PLUS) num_phase = PH_SIGNED;
            else if (it.char_code == CH_ZERO) num_phase = PH_ZERO;
            else accept_digit(it.char_code);
         end
         PH_SIGNED: begin
            if (it.char_code == CH_ZERO) num_phase = PH_ZERO;
            else accept_digit(it.char_code);
         end
         PH_ZERO: begin
            if (it.char_code == CH_LX || it.char_code == CH_UX) begin
               num_radix = RX_HEX;
               num_phase = PH_DIGITS;
            end else if (it.char_code == CH_LB || it.char_code == CH_UB) begin
               num_radix = RX_BIN;
               num_phase = PH_DIGITS;
            end else accept_digit(it.char_code);
         end
         default: accept_digit(it.char_code);
      endcase
      if (it.final_char) begin
         res.parse_ok    = num_valid;
         res.number_bits = !num_valid ? '0 : (num_negative ? -num_value : num_value);
         parsed_numbers.push_back(res);
         clear_numeral();
      end
   endfunction

   // ---- stimulus building ----
   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) numeral.push_back(s[i]);
   endtask

   task automatic emit_empty();
      char_item_type it;
      it.char_code  = 8'($urandom_range(0, 255));
      it.final_char = 1'($urandom_range(0, 1));
      it.empty_text = 1'b1;
      pending_chars.push_back(it);
   endtask

   // final_char on the last character unless the numeral is cut short
   task automatic emit_numeral(bit cut_short);
      char_item_type it;
      for (int i = 0; i < numeral.size(); i++) begin
         it.char_code  = numeral[i];
         it.final_char = !cut_short && (i == numeral.size() - 1);
         it.empty_text = 1'b0;
         pending_chars.push_back(it);
      end
      numeral.delete();
      if (cut_short) emit_empty();
   endtask

   task automatic add_digits(radix_type rx, int unsigned n);
      string hex_set;
      hex_set = "0123456789abcdefABCDEF";
      for (int i = 0; i < n; i++) begin
         case (rx)
            RX_BIN:  numeral.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
            RX_HEX:  numeral.push_back(hex_set[$urandom_range(0, 21)]);
            default: numeral.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         endcase
      end
   endtask

   task automatic add_wellformed();
      radix_type   rx;
      int unsigned n;
      int unsigned r;
      r = $urandom_range(0, 2);
      if (r == 1) numeral.push_back(CH_PLUS);
      if (r == 2) numeral.push_back(CH_MINUS);
      r = $urandom_range(0, 9);
      rx = (r < 4) ? RX_DEC : (r < 7) ? RX_HEX : RX_BIN;
      if (rx == RX_HEX) begin
         numeral.push_back(CH_ZERO);
         numeral.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      end else if (rx == RX_BIN) begin
         numeral.push_back(CH_ZERO);
         numeral.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
      end
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) numeral.push_back(CH_ZERO);
      end
      r = $urandom_range(0, 99);
      case (rx)
         RX_HEX:  n = (r < 75) ? $urandom_range(0, 6) : $urandom_range(14, 18);
         RX_BIN:  n = (r < 85) ? $urandom_range(0, 12) : $urandom_range(60, 66);
         default: n = (r < 75) ? $urandom_range(0, 8) : $urandom_range(17, 21);
      endcase
      if (n == 0 && numeral.size() == 0) n = 1;
      add_digits(rx, n);
      if ($urandom_range(0, 9) == 0)
         numeral[$urandom_range(0, numeral.size() - 1)] = 8'($urandom_range(0, 255));
   endtask

   task automatic add_boundaries();
      string lits[7];
      lits = '{"18446744073709551615", "18446744073709551616", "0xFFFFFFFFFFFFFFFF",
               "0x10000000000000000", "-9223372036854775808", "+0Xffffffffffffffff",
               "99999999999999999999"};
      foreach (lits[i]) begin
         add_str(lits[i]);
         emit_numeral(1'b0);
      end
      add_str("0b");
      for (int i = 0; i < 64; i++) numeral.push_back(CH_ONE);
      emit_numeral(1'b0);
      add_str("-0B1");
      for (int i = 0; i < 64; i++) numeral.push_back(CH_ZERO);
      emit_numeral(1'b0);
   endtask

   task automatic build_stimulus();
      int unsigned r;
      int unsigned n;
      // directed: empty, sign or prefix alone, leading zeros, invalid digits,
      // prefix after digits, second sign, extreme bytes, dropped partial
      emit_empty();
      add_str("-");   emit_numeral(1'b0);
      add_str("+");   emit_numeral(1'b0);
      add_str("0x");  emit_numeral(1'b0);
      add_str("-0b"); emit_numeral(1'b0);
      add_str("007"); emit_numeral(1'b0);
      add_str("+0z"); emit_numeral(1'b0);
      add_str("0B1"); emit_numeral(1'b0);
      add_str("1x");  emit_numeral(1'b0);
      add_str("--");  emit_numeral(1'b0);
      numeral.push_back(8'h00); numeral.push_back(8'hFF); emit_numeral(1'b0);
      add_str("12");  emit_numeral(1'b1);
      add_boundaries();
      while (pending_chars.size() < TotalChars) begin
         r = $urandom_range(0, 99);
         if (r < 7) emit_empty();
         else if (r < 17) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) numeral.push_back(8'($urandom_range(0, 255)));
            emit_numeral(1'b0);
         end else begin
            add_wellformed();
            emit_numeral($urandom_range(0, 24) == 0);
         end
      end
   endtask

   // ---- driver ----
   always @(negedge clock) begin : char_driver
      char_item_type it;
      logic          next_valid;
      next_valid = req_ch.valid;
      if (reset) next_valid = 1'b0;
      else if (!req_ch.valid || req_taken) begin
         next_valid = 1'b0;
         if (req_taken) begin
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : idle_len();
         end
         if (send_gap > 0) send_gap--;
         else if (pending_chars.size() > 0) begin
            it = pending_chars.pop_front();
            req_ch.char_code  <= it.char_code;
            req_ch.final_char <= it.final_char;
            req_ch.empty_text <= it.empty_text;
            next_valid = 1'b1;
         end
      end
      req_ch.valid <= next_valid;
   end

   always @(negedge clock) begin : result_sink
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
         if (!take_burst && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin : parse_monitor
      char_item_type     it;
      parsed_number_type want;
      if (reset) req_taken <= 1'b0;
      else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (parsed_numbers.size() == 0) begin
               $error("unexpected transaction: number_bits %h, parse_ok %b",
                      rsp_ch.number_bits, rsp_ch.parse_ok);
               mismatch_count++;
            end else begin
               want = parsed_numbers.pop_front();
               if (rsp_ch.number_bits !== want.number_bits) begin
                  $error("number_bits: expected %h, actual %h",
                         want.number_bits, rsp_ch.number_bits);
                  mismatch_count++;
               end
               if (rsp_ch.parse_ok !== want.parse_ok) begin
                  $error("parse_ok: expected %b, actual %b", want.parse_ok, rsp_ch.parse_ok);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            it.char_code  = req_ch.char_code;
            it.final_char = req_ch.final_char;
            it.empty_text = req_ch.empty_text;
            parse_char(it);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.char_code  = '0;
      req_ch.final_char = 1'b0;
      req_ch.empty_text = 1'b0;
      rsp_ch.ready      = 1'b0;
      clear_numeral();
      build_stimulus();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_chars.size() != 0 || req_ch.valid || parsed_numbers.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && parsed_numbers.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ttip_pkg.sv
rtl/core/ttip_if.sv
rtl/core/text_to_integer_parser_unit.sv
bench/tb.sv
